// ----- rtl/uart_frame_parser_decoder_core_defines.svh -----
// Assertion macros for the frame parser and decoder.
`ifndef UART_FRAME_PARSER_DECODER_CORE_DEFINES_SVH
`define UART_FRAME_PARSER_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define UFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define UFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define UFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ufp_pkg.sv -----
package ufp_pkg;

    localparam int UFP_PAYLOAD_STORE_BYTES = 64;
    localparam int DEC_BYTES = 22;
    localparam int DEC_IDX_W = 5;

    localparam logic [7:0] SYNC_BYTE  = 8'hA5;
    localparam logic [7:0] MAX_LEN    = 8'h43;
    localparam logic [7:0] OP_KEY     = 8'h3A;
    localparam logic [7:0] OP_LCD     = 8'h39;
    localparam logic [7:0] OP_STATUS  = 8'h35;
    localparam logic [7:0] OP_SENSOR  = 8'hFC;
    localparam logic [7:0] OP_BADGE_A = 8'h37;
    localparam logic [7:0] OP_BADGE_B = 8'hFE;
    localparam logic [7:0] OP_RTC_A   = 8'h38;
    localparam logic [7:0] OP_RTC_B   = 8'hFB;

    localparam logic [4:0] IC_REPORT = 5'd0;
    localparam logic [4:0] IC_KEY    = 5'd1;
    localparam logic [4:0] IC_LCD    = 5'd2;
    localparam logic [4:0] IC_PCT    = 5'd3;
    localparam logic [4:0] IC_CAPS   = 5'd5;
    localparam logic [4:0] IC_SENSOR = 5'd10;
    localparam logic [4:0] IC_BADGE  = 5'd15;
    localparam logic [4:0] IC_RTC    = 5'd19;

    typedef enum logic [6:0] {
        ST_START   = 7'b0000001,
        ST_OPCODE  = 7'b0000010,
        ST_LEN_HI  = 7'b0000100,
        ST_LEN_LO  = 7'b0001000,
        ST_PAYLOAD = 7'b0010000,
        ST_CHECK   = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } ufp_state_t;

    typedef struct packed {
        logic load_op;
        logic load_len_hi;
        logic load_len_lo;
        logic store_pay;
        logic finish;
        logic emit_load;
    } ufp_cmd_t;

    typedef struct packed {
        logic is_sync;
        logic len_over;
        logic len_zero;
        logic pay_last;
        logic emit_last;
        logic out_free;
    } ufp_status_t;

endpackage

// ----- rtl/ufp_ctrl.sv -----
module ufp_ctrl
    import ufp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ufp_status_t status,
    output ufp_cmd_t    cmd
);

    ufp_state_t state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg != ST_EMIT);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_START: begin
                if (accept && status.is_sync) state_next = ST_OPCODE;
            end
            ST_OPCODE: begin
                if (accept) begin
                    cmd.load_op = 1'b1;
                    state_next  = ST_LEN_HI;
                end
            end
            ST_LEN_HI: begin
                if (accept) begin
                    cmd.load_len_hi = 1'b1;
                    state_next      = ST_LEN_LO;
                end
            end
            ST_LEN_LO: begin
                if (accept) begin
                    cmd.load_len_lo = 1'b1;
                    if (status.len_over) state_next = ST_START;
                    else if (status.len_zero) state_next = ST_CHECK;
                    else state_next = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                if (accept) begin
                    cmd.store_pay = 1'b1;
                    if (status.pay_last) state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (accept) begin
                    cmd.finish = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last) state_next = ST_START;
                end
            end
            default: state_next = ST_START;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_START;
        else state_reg <= state_next;
    end

endmodule

// ----- rtl/ufp_dp.sv -----
module ufp_dp
    import ufp_pkg::*;
#(
    parameter int PAYLOAD_STORE_BYTES = UFP_PAYLOAD_STORE_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_ready,
    input  ufp_cmd_t           cmd,
    output ufp_status_t        status,
    output logic               m_valid,
    output logic [7:0]         m_frame_opcode,
    output logic [6:0]         m_frame_length,
    output logic               m_checksum_good,
    output logic [4:0]         m_item_code,
    output logic signed [16:0] m_item_value,
    output logic               m_last_item
);

    logic [7:0] op_reg, len_hi_reg, sum_reg;
    logic [6:0] len_reg, cnt_reg;
    logic [7:0] pay_reg [DEC_BYTES];
    logic       good_reg, bat_em_reg;
    logic [3:0] n_items_reg;
    logic [2:0] step_reg;
    logic [7:0] snap_pct_reg, snap_chg_reg;
    logic [7:0] snap_v_reg [5];
    logic       valid_reg;

    logic [6:0] cnt_inc;
    logic       ok, p0z, bat_on, st_on, bat_ch, st_ch;
    logic [7:0] pct_new, chg_new;
    logic [7:0] v_new [5];
    logic [3:0] extra;

    assign cnt_inc = cnt_reg + 7'd1;

    assign status.is_sync   = (s_rx_byte == SYNC_BYTE);
    assign status.len_over  = (len_hi_reg != 8'd0) || (s_rx_byte > MAX_LEN);
    assign status.len_zero  = (len_hi_reg == 8'd0) && (s_rx_byte == 8'd0);
    assign status.pay_last  = (cnt_inc >= len_reg);
    assign status.emit_last = ({1'b0, step_reg} == (n_items_reg - 4'd1));
    assign status.out_free  = !valid_reg || m_ready;

    assign ok      = (~sum_reg == s_rx_byte) || (s_rx_byte == 8'hFF);
    assign p0z     = (pay_reg[0] == 8'd0);
    assign bat_on  = (len_reg >= 7'd15);
    assign st_on   = (len_reg >= 7'd22);
    assign pct_new = (pay_reg[14] > 8'd100) ? 8'd100 : pay_reg[14];
    assign chg_new = {7'd0, pay_reg[13] == 8'd2};
    assign v_new[0] = {7'd0, pay_reg[15] == 8'd2};
    assign v_new[1] = pay_reg[16];
    assign v_new[2] = pay_reg[17];
    assign v_new[3] = pay_reg[20];
    assign v_new[4] = {7'd0, pay_reg[21] == 8'd1};
    assign bat_ch  = (pct_new != snap_pct_reg) || (chg_new != snap_chg_reg);
    assign st_ch   = (v_new[0] != snap_v_reg[0]) || (v_new[1] != snap_v_reg[1])
                  || (v_new[2] != snap_v_reg[2]) || (v_new[3] != snap_v_reg[3])
                  || (v_new[4] != snap_v_reg[4]);

    always_comb begin
        extra = 4'd0;
        priority case (op_reg)
            OP_KEY:    if (len_reg >= 7'd3) extra = 4'd1;
            OP_LCD:    if (len_reg >= 7'd2 && p0z && pay_reg[1] >= 8'd1 && pay_reg[1] <= 8'd4)
                           extra = 4'd1;
            OP_STATUS: if (p0z) extra = ((bat_on && bat_ch) ? 4'd2 : 4'd0)
                                      + ((st_on && st_ch) ? 4'd5 : 4'd0);
            OP_SENSOR: if (len_reg >= 7'd11 && p0z) extra = 4'd5;
            OP_BADGE_A: if (p0z && len_reg >= 7'd13 && pay_reg[1] == 8'd1) extra = 4'd4;
            OP_BADGE_B: if (p0z && len_reg >= 7'd8) extra = 4'd4;
            OP_RTC_A, OP_RTC_B: if (len_reg >= 7'd9 && p0z) extra = 4'd6;
            default: extra = 4'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg       <= 8'd0;
            len_hi_reg   <= 8'd0;
            len_reg      <= 7'd0;
            cnt_reg      <= 7'd0;
            n_items_reg  <= 4'd1;
            step_reg     <= 3'd0;
            snap_pct_reg <= 8'hFF;
            snap_chg_reg <= 8'hFF;
            for (int i = 0; i < 5; i++) snap_v_reg[i] <= 8'hFF;
        end else begin
            if (cmd.load_op) op_reg <= s_rx_byte;
            if (cmd.load_len_hi) len_hi_reg <= s_rx_byte;
            if (cmd.load_len_lo) begin
                len_reg <= s_rx_byte[6:0];
                cnt_reg <= 7'd0;
            end
            if (cmd.store_pay) cnt_reg <= cnt_inc;
            if (cmd.finish) begin
                n_items_reg <= 4'd1 + (ok ? extra : 4'd0);
                step_reg    <= 3'd0;
                if (ok && op_reg == OP_STATUS && p0z) begin
                    if (bat_on) begin
                        snap_pct_reg <= pct_new;
                        snap_chg_reg <= chg_new;
                    end
                    if (st_on) for (int i = 0; i < 5; i++) snap_v_reg[i] <= v_new[i];
                end
            end
            if (cmd.emit_load) step_reg <= step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_len_lo) sum_reg <= op_reg + len_hi_reg + s_rx_byte;
        if (cmd.store_pay) begin
            if (cnt_reg < 7'(PAYLOAD_STORE_BYTES)) sum_reg <= sum_reg + s_rx_byte;
            if (cnt_reg < 7'(DEC_BYTES)) pay_reg[cnt_reg[DEC_IDX_W-1:0]] <= s_rx_byte;
        end
        if (cmd.finish) begin
            good_reg   <= ok;
            bat_em_reg <= bat_on && bat_ch;
        end
    end

    logic [2:0]         j, sidx;
    logic [4:0]         code;
    logic [7:0]         sel_hi, sel_lo, sbyte;
    logic               use_temp;
    logic signed [16:0] direct_val, temp_val, item_val;
    logic [15:0]        raw;
    logic [31:0]        prod;
    logic [12:0]        quot;
    logic signed [16:0] tq;
    logic [5:0]         year6;

    assign j     = step_reg - 3'd1;
    assign year6 = pay_reg[3][5:0] + 6'd48;

    always_comb begin
        sidx = bat_em_reg ? (j - 3'd2) : j;
        unique case (sidx)
            3'd0: sbyte = snap_v_reg[0];
            3'd1: sbyte = snap_v_reg[1];
            3'd2: sbyte = snap_v_reg[2];
            3'd3: sbyte = snap_v_reg[3];
            3'd4: sbyte = snap_v_reg[4];
            default: sbyte = 8'd0;
        endcase
    end

    always_comb begin
        code       = IC_REPORT;
        direct_val = 17'sd0;
        sel_hi     = 8'd0;
        sel_lo     = 8'd0;
        use_temp   = 1'b0;
        if (step_reg != 3'd0) begin
            priority case (op_reg)
                OP_KEY: begin
                    code       = IC_KEY;
                    direct_val = {9'd0, pay_reg[2]};
                end
                OP_LCD: begin
                    code       = IC_LCD;
                    direct_val = {9'd0, pay_reg[1]};
                end
                OP_STATUS: begin
                    if (bat_em_reg && j < 3'd2) begin
                        code       = IC_PCT + {2'd0, j};
                        direct_val = {9'd0, (j == 3'd0) ? snap_pct_reg : snap_chg_reg};
                    end else begin
                        code       = IC_CAPS + {2'd0, sidx};
                        direct_val = {9'd0, sbyte};
                    end
                end
                OP_SENSOR: begin
                    code = IC_SENSOR + {2'd0, j};
                    unique case (j)
                        3'd0: begin sel_hi = pay_reg[1]; sel_lo = pay_reg[2]; use_temp = 1'b1; end
                        3'd1: begin sel_hi = pay_reg[3]; sel_lo = pay_reg[4]; use_temp = 1'b1; end
                        3'd2: begin sel_hi = pay_reg[5]; sel_lo = pay_reg[6]; use_temp = 1'b1; end
                        3'd3: direct_val = {1'b0, pay_reg[7], pay_reg[8]};
                        default: direct_val = {1'b0, pay_reg[9], pay_reg[10]};
                    endcase
                end
                OP_BADGE_A, OP_BADGE_B: begin
                    code = IC_BADGE + {2'd0, j};
                    unique case (j)
                        3'd0: direct_val = {9'd0, (op_reg == OP_BADGE_A) ? pay_reg[6] : pay_reg[1]};
                        3'd1: begin sel_hi = pay_reg[2]; sel_lo = pay_reg[3]; use_temp = 1'b1; end
                        3'd2: begin
                            sel_hi   = (op_reg == OP_BADGE_A) ? pay_reg[11] : pay_reg[6];
                            sel_lo   = (op_reg == OP_BADGE_A) ? pay_reg[12] : pay_reg[7];
                            use_temp = 1'b1;
                        end
                        default: begin
                            sel_hi   = (op_reg == OP_BADGE_A) ? pay_reg[9] : pay_reg[4];
                            sel_lo   = (op_reg == OP_BADGE_A) ? pay_reg[10] : pay_reg[5];
                            use_temp = 1'b1;
                        end
                    endcase
                end
                OP_RTC_A, OP_RTC_B: begin
                    code = IC_RTC + {2'd0, j};
                    unique case (j)
                        3'd0: direct_val = 17'sd2000 + {11'd0, year6};
                        3'd1: direct_val = {13'd0, pay_reg[4][3:0]};
                        3'd2: direct_val = {12'd0, pay_reg[5][4:0]};
                        3'd3: direct_val = {12'd0, pay_reg[6][4:0]};
                        3'd4: direct_val = {11'd0, pay_reg[7][5:0]};
                        default: direct_val = {11'd0, pay_reg[8][5:0]};
                    endcase
                end
                default: code = IC_REPORT;
            endcase
        end
    end

    assign raw      = {sel_hi, sel_lo};
    assign prod     = {17'd0, raw[14:0]} * 32'd52429;
    assign quot     = prod[31:19];
    assign tq       = {4'd0, quot};
    assign temp_val = (raw == 16'hFFFF) ? -17'sd32768 : (raw[15] ? -tq : tq);
    assign item_val = use_temp ? temp_val : direct_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (cmd.emit_load) valid_reg <= 1'b1;
        else if (m_ready) valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_frame_opcode  <= op_reg;
            m_frame_length  <= len_reg;
            m_checksum_good <= good_reg;
            m_item_code     <= code;
            m_item_value    <= item_val;
            m_last_item     <= status.emit_last;
        end
    end

    assign m_valid = valid_reg;

endmodule

// ----- rtl/uart_frame_parser_decoder_core.sv -----
// Deframer and decoder for a serial keyboard status link.
// Input channel s_*: one received byte per transaction on s_rx_byte. Frames are
// 0xA5, opcode, 16-bit big-endian length (at most 67), payload, checksum byte.
// Result channel m_*: per frame, a report item (code 0) followed by up to seven
// decoded items; m_last_item marks the final one. Opcode, length and checksum
// status repeat in every item of the frame.
// s_ready stays high through the header and payload bytes, so a byte can be
// accepted in every cycle. After the checksum byte the emit sequencer loads one
// result per cycle into the output register while it is free, 1 to 8 results
// per frame, and s_ready is low until the last result of the frame is loaded.
// The first result is loaded from the emit state once the output register is free.
// A stalled receiver holds the output register and the sequencer waits; the
// last result may wait while the next frame's bytes are already accepted.
// Reset returns the parser to hunting for 0xA5 and restores the battery and
// status snapshots to 0xFF; there is no clearing pass.
`include "uart_frame_parser_decoder_core_defines.svh"
module uart_frame_parser_decoder_core
    import ufp_pkg::*;
#(
    parameter int PAYLOAD_STORE_BYTES = UFP_PAYLOAD_STORE_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_frame_opcode,
    output logic [6:0]         m_frame_length,
    output logic               m_checksum_good,
    output logic [4:0]         m_item_code,
    output logic signed [16:0] m_item_value,
    output logic               m_last_item
);

    ufp_cmd_t    cmd;
    ufp_status_t status;

    ufp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ufp_dp #(
        .PAYLOAD_STORE_BYTES (PAYLOAD_STORE_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_rx_byte       (s_rx_byte),
        .m_ready         (m_ready),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_frame_opcode  (m_frame_opcode),
        .m_frame_length  (m_frame_length),
        .m_checksum_good (m_checksum_good),
        .m_item_code     (m_item_code),
        .m_item_value    (m_item_value),
        .m_last_item     (m_last_item)
    );

    `UFP_ASSERT_IMP(a_items_need_good, aclk, aresetn, m_valid && (m_item_code != IC_REPORT), m_checksum_good)
    `UFP_ASSERT_IMP(a_report_zero, aclk, aresetn, m_valid && (m_item_code == IC_REPORT), m_item_value == 17'sd0)
    `UFP_ASSERT_NXT(a_burst_continues, aclk, aresetn, m_valid && m_ready && !m_last_item, m_valid)

endmodule

// ----- bench/uart_frame_parser_decoder_core_checker.sv -----
`timescale 1ns / 1ps
module uart_frame_parser_decoder_core_checker
    import ufp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_frame_opcode,
    input  logic [6:0]         m_frame_length,
    input  logic               m_checksum_good,
    input  logic [4:0]         m_item_code,
    input  logic signed [16:0] m_item_value,
    input  logic               m_last_item,
    output int                 fail_count,
    output int                 pending_items,
    output int                 frames_seen,
    output int                 items_seen
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_OP, PH_LHI, PH_LLO, PH_PAY, PH_SUM
    } phase_t;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [6:0]         length;
        logic               good;
        logic [4:0]         code;
        logic signed [16:0] value;
        logic               last;
    } frame_item_t;

    frame_item_t item_queue[$];
    frame_item_t frame_items[$];

    phase_t      phase;
    logic [7:0]  op_q;
    logic [15:0] len_q;
    logic [6:0]  count_q;
    logic [7:0]  store_q [0:UFP_PAYLOAD_STORE_BYTES-1];
    logic [7:0]  snap_pct, snap_chg;
    logic [7:0]  snap_stat [0:4];
    logic        good_q;

    assign pending_items = item_queue.size();

    function automatic logic [7:0] pay(int idx);
        if (idx < UFP_PAYLOAD_STORE_BYTES) return store_q[idx];
        return 8'h00;
    endfunction

    function automatic logic signed [16:0] temp_value(logic [7:0] hi, logic [7:0] lo);
        logic [15:0] raw;
        int          mag;
        raw = {hi, lo};
        if (raw == 16'hFFFF) return -17'sd32768;
        mag = int'(raw[14:0]) / 10;
        return raw[15] ? 17'(-mag) : 17'(mag);
    endfunction

    task automatic add_item(logic [4:0] code, logic signed [16:0] value);
        frame_item_t it;
        if (frame_items.size() >= 8) return;
        it.opcode = op_q;
        it.length = len_q[6:0];
        it.good   = good_q;
        it.code   = code;
        it.value  = value;
        it.last   = 1'b0;
        frame_items.push_back(it);
    endtask

    task automatic decode_status();
        logic [7:0] pct, chg;
        logic [7:0] v [0:4];
        logic       changed;
        if (pay(0) != 0) return;
        if (len_q >= 15) begin
            pct = pay(14) > 100 ? 8'd100 : pay(14);
            chg = pay(13) == 2 ? 8'd1 : 8'd0;
            changed = pct != snap_pct || chg != snap_chg;
            snap_pct = pct;
            snap_chg = chg;
            if (changed) begin
                add_item(IC_PCT, 17'(pct));
                add_item(IC_PCT + 5'd1, 17'(chg));
            end
        end
        if (len_q >= 22) begin
            v[0] = pay(15) == 2 ? 8'd1 : 8'd0;
            v[1] = pay(16);
            v[2] = pay(17);
            v[3] = pay(20);
            v[4] = pay(21) == 1 ? 8'd1 : 8'd0;
            changed = 1'b0;
            for (int k = 0; k < 5; k++) begin
                if (v[k] != snap_stat[k]) changed = 1'b1;
                snap_stat[k] = v[k];
            end
            if (changed)
                for (int k = 0; k < 5; k++) add_item(IC_CAPS + 5'(k), 17'(v[k]));
        end
    endtask

    task automatic decode_badge();
        int id, a, b, c;
        if (pay(0) != 0) return;
        if (op_q == OP_BADGE_A) begin
            if (len_q < 13 || pay(1) != 1) return;
            id = 6; a = 2; c = 9; b = 11;
        end else begin
            if (len_q < 8) return;
            id = 1; a = 2; c = 4; b = 6;
        end
        add_item(IC_BADGE, 17'(pay(id)));
        add_item(IC_BADGE + 5'd1, temp_value(pay(a), pay(a + 1)));
        add_item(IC_BADGE + 5'd2, temp_value(pay(b), pay(b + 1)));
        add_item(IC_BADGE + 5'd3, temp_value(pay(c), pay(c + 1)));
    endtask

    task automatic decode_rtc();
        logic [15:0] yr;
        if (len_q < 9 || pay(0) != 0) return;
        yr = ({pay(2), pay(3)} + 16'd48) & 16'h3F;
        add_item(IC_RTC, 17'(2000 + yr));
        add_item(IC_RTC + 5'd1, 17'(pay(4) & 8'h0F));
        add_item(IC_RTC + 5'd2, 17'(pay(5) & 8'h1F));
        add_item(IC_RTC + 5'd3, 17'(pay(6) & 8'h1F));
        add_item(IC_RTC + 5'd4, 17'(pay(7) & 8'h3F));
        add_item(IC_RTC + 5'd5, 17'(pay(8) & 8'h3F));
    endtask

    task automatic close_frame(logic [7:0] chk);
        logic [7:0] sum;
        int         n;
        sum = op_q + len_q[15:8] + len_q[7:0];
        n = len_q > UFP_PAYLOAD_STORE_BYTES ? UFP_PAYLOAD_STORE_BYTES : int'(len_q);
        for (int j = 0; j < n; j++) sum = sum + store_q[j];
        good_q = (~sum == chk) || (chk == 8'hFF);
        frame_items.delete();
        add_item(IC_REPORT, 17'sd0);
        if (good_q) begin
            case (op_q)
                OP_KEY: if (len_q >= 3) add_item(IC_KEY, 17'(pay(2)));
                OP_LCD:
                    if (len_q >= 2 && pay(0) == 0 && pay(1) >= 1 && pay(1) <= 4)
                        add_item(IC_LCD, 17'(pay(1)));
                OP_STATUS: decode_status();
                OP_SENSOR: begin
                    if (len_q >= 11 && pay(0) == 0) begin
                        add_item(IC_SENSOR, temp_value(pay(1), pay(2)));
                        add_item(IC_SENSOR + 5'd1, temp_value(pay(3), pay(4)));
                        add_item(IC_SENSOR + 5'd2, temp_value(pay(5), pay(6)));
                        add_item(IC_SENSOR + 5'd3, 17'({pay(7), pay(8)}));
                        add_item(IC_SENSOR + 5'd4, 17'({pay(9), pay(10)}));
                    end
                end
                OP_BADGE_A, OP_BADGE_B: decode_badge();
                OP_RTC_A, OP_RTC_B: decode_rtc();
                default: ;
            endcase
        end
        frame_items[frame_items.size() - 1].last = 1'b1;
        foreach (frame_items[i]) item_queue.push_back(frame_items[i]);
        frames_seen++;
        phase = PH_HUNT;
    endtask

    task automatic take_byte(logic [7:0] b);
        case (phase)
            PH_OP: begin op_q = b; phase = PH_LHI; end
            PH_LHI: begin len_q = {b, 8'h00}; phase = PH_LLO; end
            PH_LLO: begin
                len_q[7:0] = b;
                count_q = 0;
                if (len_q > 16'(MAX_LEN)) phase = PH_HUNT;
                else if (len_q == 0) phase = PH_SUM;
                else phase = PH_PAY;
            end
            PH_PAY: begin
                if (count_q < UFP_PAYLOAD_STORE_BYTES) store_q[count_q] = b;
                count_q = count_q + 7'd1;
                if (16'(count_q) >= len_q) phase = PH_SUM;
            end
            PH_SUM: close_frame(b);
            default: phase = b == SYNC_BYTE ? PH_OP : PH_HUNT;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_result();
        frame_item_t want;
        if (item_queue.size() == 0) begin
            report_mismatch("unexpected result, item code", m_item_code, -1);
            return;
        end
        want = item_queue.pop_front();
        items_seen++;
        if (m_frame_opcode != want.opcode)
            report_mismatch("frame_opcode", m_frame_opcode, want.opcode);
        if (m_frame_length != want.length)
            report_mismatch("frame_length", m_frame_length, want.length);
        if (m_checksum_good != want.good)
            report_mismatch("checksum_good", m_checksum_good, want.good);
        if (m_item_code != want.code)
            report_mismatch("item_code", m_item_code, want.code);
        if (m_item_value !== want.value)
            report_mismatch("item_value", m_item_value, want.value);
        if (m_last_item != want.last)
            report_mismatch("last_item", m_last_item, want.last);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase = PH_HUNT;
            op_q = 8'h00;
            len_q = 16'h0000;
            count_q = 7'd0;
            good_q = 1'b0;
            snap_pct = 8'hFF;
            snap_chg = 8'hFF;
            for (int k = 0; k < 5; k++) snap_stat[k] = 8'hFF;
            item_queue.delete();
            fail_count = 0;
            frames_seen = 0;
            items_seen = 0;
        end else begin
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) take_byte(s_rx_byte);
        end
    end

endmodule

// ----- bench/tb_uart_frame_parser_decoder_core.sv -----
`timescale 1ns / 1ps
module tb_uart_frame_parser_decoder_core;
    import ufp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_frame_opcode;
    logic [6:0]         m_frame_length;
    logic               m_checksum_good;
    logic [4:0]         m_item_code;
    logic signed [16:0] m_item_value;
    logic               m_last_item;
    int                 fail_count;
    int                 pending_items;
    int                 frames_seen;
    int                 items_seen;
    int                 cycle_count = 0;
    int                 bytes_sent;
    bit                 quiet_mode;
    bit                 hold_off_now;

    uart_frame_parser_decoder_core uut (.*);

    uart_frame_parser_decoder_core_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_uart_frame_parser_decoder_core NOT OK");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(logic [7:0] op, logic [15:0] len, logic [7:0] body [],
                              int chk_mode);
        logic [7:0] sum;
        sum = op + len[15:8] + len[7:0];
        send_byte(SYNC_BYTE);
        send_byte(op);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len > 16'(MAX_LEN)) return;
        for (int i = 0; i < int'(len); i++) begin
            send_byte(body[i]);
            if (i < UFP_PAYLOAD_STORE_BYTES) sum = sum + body[i];
        end
        case (chk_mode)
            0: send_byte(~sum);
            1: send_byte(8'hFF);
            default: send_byte(~sum ^ 8'(1 << $urandom_range(0, 7)));
        endcase
    endtask

    task automatic random_frame(logic [7:0] op, int len);
        logic [7:0] body [];
        int         mode;
        body = new[len];
        foreach (body[i]) body[i] = 8'($urandom);
        if (len > 0 && $urandom_range(0, 4) != 0) body[0] = 8'h00;
        if (op == OP_BADGE_A && len > 1 && $urandom_range(0, 2) != 0) body[1] = 8'h01;
        if (op == OP_LCD && len > 1 && $urandom_range(0, 2) != 0)
            body[1] = 8'($urandom_range(0, 5));
        if (op == OP_STATUS && len > 21) begin
            body[13] = 8'($urandom_range(1, 3));
            body[14] = 8'($urandom_range(95, 105));
            body[15] = 8'($urandom_range(1, 3));
            body[16] = 8'($urandom_range(0, 1));
            body[17] = 8'($urandom_range(0, 1));
            body[20] = 8'($urandom_range(0, 1));
            body[21] = 8'($urandom_range(0, 2));
        end
        for (int i = 1; i + 1 < len; i += 2)
            if ($urandom_range(0, 7) == 0) begin
                body[i] = 8'hFF;
                body[i + 1] = 8'hFF;
            end
        mode = $urandom_range(0, 9);
        send_frame(op, 16'(len), body, mode < 7 ? 0 : (mode < 9 ? 2 : 1));
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [7:0] ops [9];
        ops = '{OP_KEY, OP_LCD, OP_STATUS, OP_SENSOR, OP_BADGE_A, OP_BADGE_B,
                OP_RTC_A, OP_RTC_B, 8'h00};
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return ops[$urandom_range(0, 7)];
    endfunction

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_now && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        logic [7:0] body [];
        int         len;
        bytes_sent = 0;
        quiet_mode = 1'b0;
        hold_off_now = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        body = new[67];
        foreach (body[i]) body[i] = 8'(i * 7);
        body[0] = 8'h00;
        send_frame(8'h12, 16'd0, body, 0);
        send_frame(OP_KEY, 16'd3, body, 1);
        send_frame(OP_SENSOR, 16'd67, body, 0);
        send_frame(OP_RTC_A, 16'h0100, body, 0);
        send_byte(8'hA4);
        body[0] = 8'h00; body[1] = 8'hFF; body[2] = 8'hFF; body[3] = 8'h80;
        body[4] = 8'h00; body[5] = 8'h7F; body[6] = 8'hFF;
        send_frame(OP_SENSOR, 16'd11, body, 2);
        send_frame(OP_SENSOR, 16'd11, body, 0);
        body[1] = 8'd4;
        send_frame(OP_LCD, 16'd2, body, 0);
        send_frame(OP_STATUS, 16'd22, body, 0);
        send_frame(OP_STATUS, 16'd22, body, 0);
        send_frame(OP_STATUS, 16'd15, body, 0);
        send_frame(OP_BADGE_B, 16'd8, body, 0);
        send_frame(OP_RTC_B, 16'd9, body, 0);

        hold_off_now = 1'b1;
        for (int f = 0; f < 4; f++) random_frame(OP_SENSOR, 11);

        while (bytes_sent < 480) begin
            if (bytes_sent > 420) quiet_mode = 1'b1;
            if ($urandom_range(0, 12) == 0) begin
                send_byte(8'($urandom));
            end else begin
                len = $urandom_range(0, 20) == 0 ? $urandom_range(23, 67)
                                                 : $urandom_range(0, 24);
                if ($urandom_range(0, 25) == 0) len = $urandom_range(68, 300);
                if (len > 67) send_frame(pick_opcode(), 16'(len), body, 0);
                else random_frame(pick_opcode(), len);
            end
        end
        s_valid <= 1'b0;

        while (pending_items != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Run sent %0d bytes in %0d frames and checked %0d results.",
                 bytes_sent, frames_seen, items_seen);
        if (fail_count == 0 && pending_items == 0)
            $display("tb_uart_frame_parser_decoder_core OK");
        else
            $display("tb_uart_frame_parser_decoder_core NOT OK");
        $finish;
    end

endmodule
